// ===== hdl/distance_delta_bit_packer_unit_macros.svh =====
// Assertion macros shared by the distance delta bit packer RTL.
`ifndef DISTANCE_DELTA_BIT_PACKER_UNIT_MACROS_SVH
`define DISTANCE_DELTA_BIT_PACKER_UNIT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define DDBP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Condition that must never be true outside of reset.
`define DDBP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);

`endif

// ===== hdl/ddbp_pkg.sv =====
// Types and constants for the distance delta bit packer.
`timescale 1ns / 1ps

package ddbp_pkg;

    localparam int C_DIST_W      = 16;
    localparam int C_ESCAPE_BITS = 8;
    localparam int C_PEND_W      = 7;

    typedef enum logic {
        CMD_CODE  = 1'b0,
        CMD_FLUSH = 1'b1
    } t_command;

    typedef struct packed {
        t_command              command;
        logic [C_DIST_W-1:0]   distance_code;
        logic                  face_start;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_beat;

endpackage

// ===== hdl/distance_delta_bit_packer_unit.sv =====
// Distance delta bit packer: zigzag delta coding with escape, packed MSB first into bytes.
`timescale 1ns / 1ps
`include "distance_delta_bit_packer_unit_macros.svh"

// An input beat lands in an input register. From there one pass of logic forms the
// zigzag delta of the distance against the previous one, picks the 9-bit short code or
// the 17-bit escape code, merges it behind up to seven pending bits and cuts out the
// whole bytes, zero to three of them, into a byte group register. The group drains one
// byte per output beat, and the last byte of each input beat carries last_byte. A new
// input beat enters every cycle while each beat yields at most one byte and i_stall is
// low; a beat that yields two or three bytes holds the input until its group is down
// to its last byte, as the output port moves a single byte per beat. A flush beat emits
// the pending bits, zero padded, as one byte, or nothing when none are pending. A byte
// reaches the output through the input register and then the byte group register.
module distance_delta_bit_packer_unit
    import ddbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);

    // Input register.
    logic                r_in_valid;
    t_in_beat            r_in;

    // Coder state.
    logic [C_DIST_W-1:0] r_prev;
    logic [C_PEND_W-1:0] r_pend_bits;
    logic [2:0]          r_pend_cnt;

    // Byte group waiting for the output port.
    logic [1:0]          r_grp_cnt;
    logic [7:0]          r_grp_b0;
    logic [7:0]          r_grp_b1;
    logic [7:0]          r_grp_b2;

    logic                take;
    logic                load;
    logic                in_take;

    logic [C_DIST_W-1:0] prev_eff;
    logic [C_DIST_W:0]   zz;
    logic                short_code;
    logic [23:0]         acc;
    logic [4:0]          total;
    logic [C_PEND_W-1:0] pend_la;
    logic [23:0]         code_l;
    logic [23:0]         word;
    logic [C_PEND_W-1:0] rem_mask;
    logic [7:0]          flush_byte;

    logic [1:0]          n_grp_cnt;
    logic [7:0]          n_b0;
    logic [7:0]          n_b1;
    logic [7:0]          n_b2;
    logic [C_DIST_W-1:0] n_prev;
    logic [C_PEND_W-1:0] n_pend_bits;
    logic [2:0]          n_pend_cnt;

    assign take    = o_valid && !i_stall;
    assign load    = r_in_valid && ((r_grp_cnt == 2'd0) || ((r_grp_cnt == 2'd1) && take));
    assign o_stall = r_in_valid && !load;
    assign in_take = i_valid && !o_stall;

    assign o_valid          = (r_grp_cnt != 2'd0);
    assign o_data.out_byte  = r_grp_b0;
    assign o_data.last_byte = (r_grp_cnt == 2'd1);

    always_comb begin
        prev_eff = r_in.face_start ? '0 : r_prev;
        if (r_in.distance_code >= prev_eff) begin
            zz = {(r_in.distance_code - prev_eff), 1'b0};
        end else begin
            zz = {(prev_eff - r_in.distance_code), 1'b0} - 17'd1;
        end
        short_code = (zz[C_DIST_W:C_ESCAPE_BITS] == '0);

        if (short_code) begin
            acc    = 24'({r_pend_bits, 1'b0, zz[C_ESCAPE_BITS-1:0]});
            total  = 5'(r_pend_cnt) + 5'd9;
            code_l = {1'b0, zz[C_ESCAPE_BITS-1:0], 15'd0};
        end else begin
            acc    = {r_pend_bits, 1'b1, r_in.distance_code};
            total  = 5'(r_pend_cnt) + 5'd17;
            code_l = {1'b1, r_in.distance_code, 7'd0};
        end

        // Pending bits left aligned, code bits directly behind them.
        pend_la    = r_pend_bits << (3'd7 - r_pend_cnt);
        word       = {pend_la, 17'd0} | (code_l >> r_pend_cnt);
        rem_mask   = 7'h7F >> (3'd7 - total[2:0]);
        flush_byte = 8'({r_pend_bits, 1'b0}) << (3'd7 - r_pend_cnt);
    end

    always_comb begin
        n_prev      = r_prev;
        n_pend_bits = r_pend_bits;
        n_pend_cnt  = r_pend_cnt;
        n_grp_cnt   = r_grp_cnt;
        n_b0        = r_grp_b0;
        n_b1        = r_grp_b1;
        n_b2        = r_grp_b2;
        if (load) begin
            unique case (r_in.command)
                CMD_FLUSH: begin
                    n_grp_cnt   = (r_pend_cnt != 3'd0) ? 2'd1 : 2'd0;
                    n_b0        = flush_byte;
                    n_pend_bits = '0;
                    n_pend_cnt  = '0;
                end
                CMD_CODE: begin
                    n_grp_cnt   = total[4:3];
                    n_b0        = word[23:16];
                    n_b1        = word[15:8];
                    n_b2        = word[7:0];
                    n_prev      = r_in.distance_code;
                    n_pend_bits = acc[C_PEND_W-1:0] & rem_mask;
                    n_pend_cnt  = total[2:0];
                end
                default: begin
                    n_grp_cnt = r_grp_cnt;
                end
            endcase
        end else if (take) begin
            n_grp_cnt = r_grp_cnt - 2'd1;
            n_b0      = r_grp_b1;
            n_b1      = r_grp_b2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_prev      <= '0;
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_grp_cnt   <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
            r_prev      <= n_prev;
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
            r_grp_cnt   <= n_grp_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_data;
        end
        r_grp_b0 <= n_b0;
        r_grp_b1 <= n_b1;
        r_grp_b2 <= n_b2;
    end

    // A coded distance always completes at least one byte.
    `DDBP_ASSERT(a_code_gives_byte, i_clk, i_rst_n,
        (load && (r_in.command == CMD_CODE)) |=> (r_grp_cnt != 2'd0),
        "code beat produced no byte")
    // A flush yields at most one byte and leaves nothing pending.
    `DDBP_ASSERT(a_flush_one_byte, i_clk, i_rst_n,
        (load && (r_in.command == CMD_FLUSH)) |=> (r_grp_cnt <= 2'd1),
        "flush produced more than one byte")
    `DDBP_ASSERT(a_flush_clears, i_clk, i_rst_n,
        (load && (r_in.command == CMD_FLUSH)) |=> (r_pend_cnt == 3'd0),
        "pending bits survived a flush")
    // A beat held in the input register is not lost while the group drains.
    `DDBP_ASSERT(a_input_held, i_clk, i_rst_n,
        (r_in_valid && !load) |=> (r_in_valid && $stable(r_in)),
        "held input beat changed or vanished")

endmodule
